// File: rtl/cruise_stalk_controller_unit_assert.svh
`ifndef CRUISE_STALK_CONTROLLER_UNIT_ASSERT_SVH
`define CRUISE_STALK_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/csc_pkg.sv
`timescale 1ns / 1ps

package csc_pkg;

    // ladder windows, one bit wider than the sample since the up window ends above full scale
    localparam logic [12:0] UP_LO  = 13'd3600;
    localparam logic [12:0] UP_HI  = 13'd4500;
    localparam logic [12:0] DN_LO  = 13'd2600;
    localparam logic [12:0] DN_HI  = 13'd3500;
    localparam logic [12:0] DF_LO  = 13'd1600;
    localparam logic [12:0] DF_HI  = 13'd2500;
    localparam logic [12:0] DN2_LO = 13'd600;
    localparam logic [12:0] DN2_HI = 13'd1500;

    localparam logic [10:0] CRUISE_ID    = 11'h1D2;
    localparam logic [10:0] SPEED_ID     = 11'h1D3;
    localparam logic [7:0]  SPEED_B1_LOW = 8'h28;
    localparam logic [7:0]  SPEED_B1     = 8'h80 | SPEED_B1_LOW;
    localparam logic [7:0]  FRAME_LEN    = 8'd8;

    // command codes
    localparam logic CMD_LOOP  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IGNITION_TIMEOUT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIG_STEP         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_SPEED    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_FRAME_ID   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CANCEL_FRAME_ID  = 3'd5;

    typedef struct packed {
        logic [15:0] repeat_interval_ms;
        logic [15:0] ignition_timeout_ms;
        logic [7:0]  big_step;
        logic [7:0]  default_speed;
        logic [10:0] speed_frame_id;
        logic [10:0] cancel_frame_id;
    } csc_cfg_t;

    localparam csc_cfg_t CSC_CFG_RESET = '{
        repeat_interval_ms:  16'd250,
        ignition_timeout_ms: 16'd500,
        big_step:            8'd5,
        default_speed:       8'd50,
        speed_frame_id:      11'd1,
        cancel_frame_id:     11'd2
    };

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic [11:0] adc_sample;
        logic        mode_pin;
        logic [10:0] frame_id;
        logic [7:0]  frame_byte;
    } csc_item_t;

    typedef struct packed {
        logic        frames_valid;
        logic        ignition_on;
        logic        cruise_on;
        logic [63:0] cruise_frame;
        logic [63:0] speed_frame;
    } csc_result_t;

    // index 0 is speed up, index 1 is speed down
    typedef struct packed {
        logic            engaged;
        logic [15:0]     target_speed;
        logic [15:0]     resume_speed;
        logic            ignition;
        logic [31:0]     last_seen_ms;
        logic            big_hop;
        logic [1:0]      button_held;
        logic [1:0][31:0] hold_start_ms;
        logic            mode_prev;
        logic            mode_latched;
    } csc_state_t;

    localparam csc_state_t CSC_STATE_RESET = '{
        engaged:       1'b0,
        target_speed:  16'd50,
        resume_speed:  16'd0,
        ignition:      1'b0,
        last_seen_ms:  32'd0,
        big_hop:       1'b0,
        button_held:   2'b00,
        hold_start_ms: '0,
        mode_prev:     1'b0,
        mode_latched:  1'b0
    };

    // close a frame body with its byte-sum check byte
    function automatic logic [63:0] csc_seal(input logic [55:0] body, input logic [10:0] id);
        logic [7:0] sum;
        sum = {5'd0, id[10:8]} + id[7:0] + FRAME_LEN;
        for (int k = 0; k < 7; k++) begin
            sum = sum + body[8*k +: 8];
        end
        return {sum, body};
    endfunction

endpackage

// File: rtl/csc_step.sv
`timescale 1ns / 1ps

module csc_step (
    input  csc_pkg::csc_cfg_t    cfg_i,
    input  csc_pkg::csc_state_t  state_i,
    input  csc_pkg::csc_item_t   item_i,
    output csc_pkg::csc_state_t  state_o,
    output csc_pkg::csc_result_t result_o
);

    csc_pkg::csc_state_t st;
    csc_pkg::csc_result_t res;

    logic [31:0] since_seen;
    logic [31:0] held_up_ms;
    logic [31:0] held_dn_ms;
    logic [12:0] adc_w;
    logic        up_win;
    logic        dn_win;
    logic        dist_win;
    logic        repeat_up;
    logic        repeat_dn;
    logic [15:0] big_step_w;

    assign since_seen = item_i.now_ms - state_i.last_seen_ms;
    assign held_up_ms = item_i.now_ms - state_i.hold_start_ms[0];
    assign held_dn_ms = item_i.now_ms - state_i.hold_start_ms[1];
    assign repeat_up  = held_up_ms >= {16'd0, cfg_i.repeat_interval_ms};
    assign repeat_dn  = held_dn_ms >= {16'd0, cfg_i.repeat_interval_ms};
    assign big_step_w = {8'd0, cfg_i.big_step};
    assign adc_w      = {1'b0, item_i.adc_sample};

    assign up_win   = (adc_w >= csc_pkg::UP_LO) && (adc_w <= csc_pkg::UP_HI);
    assign dn_win   = (adc_w >= csc_pkg::DN_LO) && (adc_w <= csc_pkg::DN_HI);
    // distance buttons: no effect on speed or holds
    assign dist_win = ((adc_w >= csc_pkg::DF_LO) && (adc_w <= csc_pkg::DF_HI))
                   || ((adc_w >= csc_pkg::DN2_LO) && (adc_w <= csc_pkg::DN2_HI));

    always_comb begin
        st  = state_i;
        res = '0;
        if (item_i.command == csc_pkg::CMD_FRAME) begin
            if (item_i.frame_id == cfg_i.speed_frame_id) begin
                st.ignition     = 1'b1;
                st.last_seen_ms = item_i.now_ms;
                if (!st.engaged) begin
                    st.target_speed = {8'd0, item_i.frame_byte};
                end
            end else if (item_i.frame_id == cfg_i.cancel_frame_id) begin
                st.resume_speed = st.target_speed;
                st.engaged      = 1'b0;
            end
        end else begin
            if (since_seen > {16'd0, cfg_i.ignition_timeout_ms}) begin
                st.ignition = 1'b0;
            end
            if (st.ignition) begin
                if (up_win) begin
                    if (!st.button_held[0]) begin
                        st.hold_start_ms[0] = item_i.now_ms;
                        st.button_held[0]   = 1'b1;
                        if (!st.engaged) begin
                            st.engaged      = 1'b1;
                            st.target_speed = st.resume_speed;
                        end
                    end else if (repeat_up) begin
                        st.hold_start_ms[0] = item_i.now_ms;
                        if (st.engaged) begin
                            st.target_speed = st.target_speed + big_step_w;
                            st.big_hop      = 1'b1;
                        end
                    end
                end else if (dn_win) begin
                    if (!st.button_held[1]) begin
                        st.hold_start_ms[1] = item_i.now_ms;
                        st.button_held[1]   = 1'b1;
                    end else if (repeat_dn) begin
                        st.hold_start_ms[1] = item_i.now_ms;
                        if (st.engaged) begin
                            st.target_speed = st.target_speed - big_step_w;
                            st.big_hop      = 1'b1;
                        end
                    end
                end else if (!dist_win) begin
                    // release: up first, a pending big hop eats one tap step
                    if (st.button_held[0]) begin
                        if (!st.big_hop) begin
                            st.target_speed = st.target_speed + 16'd1;
                        end else begin
                            st.big_hop = 1'b0;
                        end
                        st.button_held[0]   = 1'b0;
                        st.hold_start_ms[0] = '0;
                    end
                    if (st.button_held[1]) begin
                        if (!st.big_hop) begin
                            st.target_speed = st.target_speed - 16'd1;
                        end else begin
                            st.big_hop = 1'b0;
                        end
                        st.button_held[1]   = 1'b0;
                        st.hold_start_ms[1] = '0;
                    end
                end

                // mode toggles on a latched rising edge
                if (item_i.mode_pin) begin
                    if (!st.mode_prev) begin
                        if (!st.mode_latched) begin
                            st.engaged = !st.engaged;
                        end
                        st.mode_latched = 1'b1;
                    end else begin
                        st.mode_latched = 1'b0;
                    end
                end
                st.mode_prev = item_i.mode_pin;

                res.frames_valid = 1'b1;
                res.cruise_frame = csc_pkg::csc_seal(
                    {8'd0, st.engaged, 7'd0, 32'd0, 2'b00, st.engaged, 5'd0},
                    csc_pkg::CRUISE_ID);
                res.speed_frame  = csc_pkg::csc_seal(
                    {32'd0, st.target_speed[7:0], csc_pkg::SPEED_B1, 8'd0},
                    csc_pkg::SPEED_ID);
            end else begin
                st.target_speed = {8'd0, cfg_i.default_speed};
                st.engaged      = 1'b0;
            end
        end
        res.ignition_on = st.ignition;
        res.cruise_on   = st.engaged;
    end

    assign state_o  = st;
    assign result_o = res;

endmodule

// File: rtl/cruise_stalk_controller_unit.sv
// Cruise stalk controller.
// Input stream s_axis: tuser is the command (0 loop pass, 1 received frame),
// tdata carries the time stamp, ladder sample, mode pin and frame fields.
// Every request gives exactly one result on m_axis: tuser says whether the
// two output frames are valid, tdata holds the flags and both frames.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 repeat
// interval, 1 ignition timeout, 2 big step, 3 default speed, 4 speed frame
// id, 5 cancel frame id); other indexes are ignored.
// A request taken is held in the input register; the state update then loads
// its result into the result register. Throughput: one request per cycle while
// m_axis_tready is high, set by the combinational state update between them.
// When m_axis_tready is low the result register holds and the input
// register still takes one more request; after that s_axis_tready drops.
// Reset (aresetn low, synchronous) empties both registers and loads the
// register defaults and the idle controller state.
`timescale 1ns / 1ps
`include "cruise_stalk_controller_unit_assert.svh"

module cruise_stalk_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [csc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [csc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms[31:0], adc_sample[43:32], mode_pin[44], frame_id[55:45], frame_byte[63:56]
    input  logic [63:0]                         s_axis_tdata,
    // command[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ignition_on[0], cruise_on[1], cruise_frame[65:2], speed_frame[129:66], zero[135:130]
    output logic [135:0]                        m_axis_tdata,
    // frames_valid[0]
    output logic                                m_axis_tuser
);

    csc_pkg::csc_cfg_t    cfg_reg,   cfg_next;
    csc_pkg::csc_state_t  state_reg, state_next;
    csc_pkg::csc_item_t   in_item_reg, in_item_next;
    csc_pkg::csc_result_t out_res_reg, out_res_next;
    csc_pkg::csc_result_t step_res;
    csc_pkg::csc_state_t  step_state;
    logic                 in_valid_reg,  in_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 step_go;
    logic                 in_take;

    assign step_go       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    csc_step u_step (
        .cfg_i    (cfg_reg),
        .state_i  (state_reg),
        .item_i   (in_item_reg),
        .state_o  (step_state),
        .result_o (step_res)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                csc_pkg::REG_REPEAT_INTERVAL:  cfg_next.repeat_interval_ms  = cfg_wdata;
                csc_pkg::REG_IGNITION_TIMEOUT: cfg_next.ignition_timeout_ms = cfg_wdata;
                csc_pkg::REG_BIG_STEP:         cfg_next.big_step            = cfg_wdata[7:0];
                csc_pkg::REG_DEFAULT_SPEED:    cfg_next.default_speed       = cfg_wdata[7:0];
                csc_pkg::REG_SPEED_FRAME_ID:   cfg_next.speed_frame_id      = cfg_wdata[10:0];
                csc_pkg::REG_CANCEL_FRAME_ID:  cfg_next.cancel_frame_id     = cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item_next            = in_item_reg;
        in_item_next.command    = s_axis_tuser;
        in_item_next.now_ms     = s_axis_tdata[31:0];
        in_item_next.adc_sample = s_axis_tdata[43:32];
        in_item_next.mode_pin   = s_axis_tdata[44];
        in_item_next.frame_id   = s_axis_tdata[55:45];
        in_item_next.frame_byte = s_axis_tdata[63:56];
        if (!in_take) begin
            in_item_next = in_item_reg;
        end
    end

    assign in_valid_next  = in_take ? 1'b1 : (step_go ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_go ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    assign state_next     = step_go ? step_state : state_reg;
    assign out_res_next   = step_go ? step_res : out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= csc_pkg::CSC_CFG_RESET;
            state_reg     <= csc_pkg::CSC_STATE_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.frames_valid;
    assign m_axis_tdata  = {6'd0, out_res_reg.speed_frame, out_res_reg.cruise_frame,
                            out_res_reg.cruise_on, out_res_reg.ignition_on};

    `CSC_ASSERT_NEXT(a_step_loads_result, step_go, out_valid_reg, "processed request left no result")
    `CSC_ASSERT_NEXT(a_input_held, in_valid_reg && !step_go, in_valid_reg, "pending request was lost")
    `CSC_ASSERT_NOW(a_frames_need_ignition, out_valid_reg && out_res_reg.frames_valid, out_res_reg.ignition_on, "frames sent with ignition off")
    `CSC_ASSERT_NOW(a_idle_frames_zero, out_valid_reg && !out_res_reg.frames_valid, (out_res_reg.cruise_frame == 64'd0) && (out_res_reg.speed_frame == 64'd0), "invalid frames are not zero")

endmodule

// File: dv/tb_cruise_stalk_controller_unit.sv
`timescale 1ns / 1ps

module tb_cruise_stalk_controller_unit;

    // ladder windows in adc counts
    localparam int unsigned UP_MIN        = 3600;
    localparam int unsigned UP_MAX        = 4500;
    localparam int unsigned DOWN_MIN      = 2600;
    localparam int unsigned DOWN_MAX      = 3500;
    localparam int unsigned DIST_HI_MIN   = 1600;
    localparam int unsigned DIST_HI_MAX   = 2500;
    localparam int unsigned DIST_LO_MIN   = 600;
    localparam int unsigned DIST_LO_MAX   = 1500;
    localparam int unsigned ADC_FULL      = 4095;

    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;

    localparam int ZONE_UP       = 0;
    localparam int ZONE_DOWN     = 1;
    localparam int ZONE_DISTANCE = 2;
    localparam int ZONE_OPEN     = 3;

    localparam logic [csc_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [csc_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [csc_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [csc_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [135:0]                   m_axis_tdata;
    logic                           m_axis_tuser;

    cruise_stalk_controller_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    csc_pkg::csc_cfg_t      regs;
    csc_pkg::csc_state_t    ctl;
    csc_pkg::csc_result_t   report_queue[$];
    int unsigned   fail_count = 0;
    bit            steady_flow = 1'b0;
    bit            long_stall_req = 1'b0;
    logic [31:0]   clock_ms = '0;
    int            held_zone = ZONE_OPEN;
    bit            mode_level = 1'b0;

    // ---------------- controller prediction ----------------

    function automatic void reset_model();
        regs.repeat_interval_ms  = 16'd250;
        regs.ignition_timeout_ms = 16'd500;
        regs.big_step            = 8'd5;
        regs.default_speed       = 8'd50;
        regs.speed_frame_id      = 11'd1;
        regs.cancel_frame_id     = 11'd2;
        ctl = '0;
        ctl.target_speed = 16'd50;
    endfunction

    function automatic void store_register(input logic [csc_pkg::CFG_ADDR_W-1:0] idx,
                                           input logic [csc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            csc_pkg::REG_REPEAT_INTERVAL:  regs.repeat_interval_ms  = data;
            csc_pkg::REG_IGNITION_TIMEOUT: regs.ignition_timeout_ms = data;
            csc_pkg::REG_BIG_STEP:         regs.big_step            = data[7:0];
            csc_pkg::REG_DEFAULT_SPEED:    regs.default_speed       = data[7:0];
            csc_pkg::REG_SPEED_FRAME_ID:   regs.speed_frame_id      = data[10:0];
            csc_pkg::REG_CANCEL_FRAME_ID:  regs.cancel_frame_id     = data[10:0];
            default: ;
        endcase
    endfunction

    function automatic logic [63:0] with_check_byte(input logic [55:0] body,
                                                    input logic [10:0] id);
        int unsigned total;
        int k;
        total = id[10:8] + id[7:0] + csc_pkg::FRAME_LEN;
        for (k = 0; k < 7; k++) begin
            total = total + body[8*k +: 8];
        end
        return {total[7:0], body};
    endfunction

    function automatic void press_button(input int b, input logic [31:0] now);
        logic [31:0] held_ms;
        held_ms = now - ctl.hold_start_ms[b];
        if (!ctl.button_held[b]) begin
            ctl.hold_start_ms[b] = now;
            ctl.button_held[b] = 1'b1;
            if (b == BTN_UP && !ctl.engaged) begin
                ctl.engaged = 1'b1;
                ctl.target_speed = ctl.resume_speed;
            end
        end else if (held_ms >= regs.repeat_interval_ms) begin
            ctl.hold_start_ms[b] = now;
            if (ctl.engaged) begin
                if (b == BTN_UP) begin
                    ctl.target_speed = ctl.target_speed + regs.big_step;
                end else begin
                    ctl.target_speed = ctl.target_speed - regs.big_step;
                end
                ctl.big_hop = 1'b1;
            end
        end
    endfunction

    // up is visited first, a pending big step eats the first tap
    function automatic void release_buttons();
        int b;
        for (b = BTN_UP; b <= BTN_DOWN; b++) begin
            if (ctl.button_held[b]) begin
                if (!ctl.big_hop) begin
                    ctl.target_speed = (b == BTN_UP) ? ctl.target_speed + 16'd1
                                                     : ctl.target_speed - 16'd1;
                end else begin
                    ctl.big_hop = 1'b0;
                end
                ctl.button_held[b] = 1'b0;
                ctl.hold_start_ms[b] = '0;
            end
        end
    endfunction

    function automatic csc_pkg::csc_result_t advance_controller(input csc_pkg::csc_item_t it);
        csc_pkg::csc_result_t r;
        logic [31:0] quiet_ms;
        r = '0;
        if (it.command == csc_pkg::CMD_FRAME) begin
            // speed frame wins when both ids match
            if (it.frame_id == regs.speed_frame_id) begin
                ctl.ignition = 1'b1;
                ctl.last_seen_ms = it.now_ms;
                if (!ctl.engaged) ctl.target_speed = {8'd0, it.frame_byte};
            end else if (it.frame_id == regs.cancel_frame_id) begin
                ctl.resume_speed = ctl.target_speed;
                ctl.engaged = 1'b0;
            end
        end else begin
            quiet_ms = it.now_ms - ctl.last_seen_ms;
            if (quiet_ms > regs.ignition_timeout_ms) ctl.ignition = 1'b0;
            if (ctl.ignition) begin
                if (it.adc_sample >= UP_MIN && it.adc_sample <= UP_MAX) begin
                    press_button(BTN_UP, it.now_ms);
                end else if (it.adc_sample >= DOWN_MIN && it.adc_sample <= DOWN_MAX) begin
                    press_button(BTN_DOWN, it.now_ms);
                end else if (!((it.adc_sample >= DIST_HI_MIN && it.adc_sample <= DIST_HI_MAX) ||
                               (it.adc_sample >= DIST_LO_MIN && it.adc_sample <= DIST_LO_MAX))) begin
                    release_buttons();
                end
                if (it.mode_pin) begin
                    if (!ctl.mode_prev) begin
                        if (!ctl.mode_latched) ctl.engaged = !ctl.engaged;
                        ctl.mode_latched = 1'b1;
                    end else begin
                        ctl.mode_latched = 1'b0;
                    end
                end
                ctl.mode_prev = it.mode_pin;
                r.frames_valid = 1'b1;
                r.cruise_frame = with_check_byte({8'h00, ctl.engaged, 7'd0, 32'd0,
                                                  2'd0, ctl.engaged, 5'd0}, csc_pkg::CRUISE_ID);
                r.speed_frame  = with_check_byte({32'd0, ctl.target_speed[7:0],
                                                  csc_pkg::SPEED_B1, 8'h00}, csc_pkg::SPEED_ID);
            end else begin
                ctl.target_speed = {8'd0, regs.default_speed};
                ctl.engaged = 1'b0;
            end
        end
        r.ignition_on = ctl.ignition;
        r.cruise_on = ctl.engaged;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned pick_span(input int unsigned lo, input int unsigned hi);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? lo : hi;
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [11:0] ladder_value(input int zone);
        case (zone)
            ZONE_UP:   return 12'(pick_span(UP_MIN, ADC_FULL));
            ZONE_DOWN: return 12'(pick_span(DOWN_MIN, DOWN_MAX));
            ZONE_DISTANCE: begin
                if ($urandom_range(0, 1)) return 12'(pick_span(DIST_HI_MIN, DIST_HI_MAX));
                return 12'(pick_span(DIST_LO_MIN, DIST_LO_MAX));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 12'(pick_span(0, DIST_LO_MIN - 1));
                    1:       return 12'(pick_span(DIST_LO_MAX + 1, DIST_HI_MIN - 1));
                    2:       return 12'(pick_span(DIST_HI_MAX + 1, DOWN_MIN - 1));
                    default: return 12'(pick_span(DOWN_MAX + 1, UP_MIN - 1));
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] next_dt();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 30);
            6, 7:             return regs.repeat_interval_ms + $urandom_range(0, 2) - 1;
            8:                return $urandom_range(0, regs.ignition_timeout_ms + 1);
            default:          return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic push_item(input csc_pkg::csc_item_t it);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 30) gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.command;
        s_axis_tdata  <= {it.frame_byte, it.frame_id, it.mode_pin, it.adc_sample, it.now_ms};
        do @(posedge aclk); while (!s_axis_tready);
        report_queue.push_back(advance_controller(it));
    endtask

    task automatic send_loop(input logic [31:0] now, input logic [11:0] adc, input logic pin);
        csc_pkg::csc_item_t it;
        it.command    = csc_pkg::CMD_LOOP;
        it.now_ms     = now;
        it.adc_sample = adc;
        it.mode_pin   = pin;
        it.frame_id   = 11'($urandom);
        it.frame_byte = 8'($urandom);
        push_item(it);
    endtask

    task automatic send_frame(input logic [31:0] now, input logic [10:0] id,
                              input logic [7:0] speed);
        csc_pkg::csc_item_t it;
        it.command    = csc_pkg::CMD_FRAME;
        it.now_ms     = now;
        it.adc_sample = 12'($urandom);
        it.mode_pin   = 1'($urandom);
        it.frame_id   = id;
        it.frame_byte = speed;
        push_item(it);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (report_queue.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [csc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [csc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        store_register(idx, data);
    endtask

    // junk above each register width must be dropped by the block
    task automatic apply_config(input logic [15:0] rpt, tmo, input logic [7:0] big, dflt,
                                input logic [10:0] sid, cid);
        logic [15:0] noise;
        settle();
        noise = 16'($urandom);
        write_reg(csc_pkg::REG_REPEAT_INTERVAL, rpt);
        write_reg(csc_pkg::REG_IGNITION_TIMEOUT, tmo);
        write_reg(csc_pkg::REG_BIG_STEP, {noise[15:8], big});
        write_reg(csc_pkg::REG_DEFAULT_SPEED, {noise[7:0], dflt});
        write_reg(csc_pkg::REG_SPEED_FRAME_ID, {noise[15:11], sid});
        write_reg(csc_pkg::REG_CANCEL_FRAME_ID, {noise[4:0], cid});
        write_reg(REG_SPARE_6, noise);
        write_reg(REG_SPARE_7, ~noise);
        cfg_we <= 1'b0;
    endtask

    // mostly button sessions with refreshing speed frames, some junk mixed in
    task automatic random_traffic(input int count);
        csc_pkg::csc_item_t it;
        int roll;
        repeat (count) begin
            clock_ms = clock_ms + next_dt();
            roll = $urandom_range(0, 99);
            it.now_ms     = clock_ms;
            it.adc_sample = 12'($urandom);
            it.mode_pin   = 1'($urandom);
            it.frame_id   = 11'($urandom);
            it.frame_byte = 8'($urandom);
            if (roll < 12) begin
                it.command  = csc_pkg::CMD_FRAME;
                it.frame_id = regs.speed_frame_id;
            end else if (roll < 16) begin
                it.command  = csc_pkg::CMD_FRAME;
                it.frame_id = regs.cancel_frame_id;
            end else if (roll < 20) begin
                it.command = csc_pkg::CMD_FRAME;
            end else if (roll < 24) begin
                it.command = csc_pkg::CMD_LOOP;
                if ($urandom_range(0, 2) == 0) it.now_ms = $urandom;
            end else begin
                it.command = csc_pkg::CMD_LOOP;
                if ($urandom_range(0, 4) == 0) held_zone = $urandom_range(ZONE_UP, ZONE_OPEN);
                if ($urandom_range(0, 3) == 0) mode_level = ~mode_level;
                it.adc_sample = ladder_value(held_zone);
                it.mode_pin   = mode_level;
            end
            push_item(it);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_button_ladder();
        send_loop(32'd5, 12'd0, 1'b0);            // ignition off forces default speed
        send_frame(32'd7, 11'd3, 8'h99);          // unknown id
        send_frame(32'd10, 11'd1, 8'd200);
        send_loop(32'd20, 12'd3600, 1'b0);        // engages at resume speed
        send_loop(32'd270, 12'd4095, 1'b0);       // one interval held: big step
        send_frame(32'd280, 11'd1, 8'd77);        // engaged, speed kept
        send_loop(32'd290, 12'd2600, 1'b0);       // down while up still held
        send_loop(32'd300, 12'd0, 1'b0);          // release both
        send_loop(32'd310, 12'd3500, 1'b0);
        send_loop(32'd560, 12'd2999, 1'b0);       // big step down wraps
        send_frame(32'd570, 11'd1, 8'hFF);
        send_loop(32'd580, 12'd1600, 1'b1);       // distance zone, mode rising
        send_loop(32'd590, 12'd2500, 1'b1);       // mode held clears latch
        send_loop(32'd600, 12'd600, 1'b0);
        send_loop(32'd610, 12'd1500, 1'b1);
        send_loop(32'd620, 12'd1599, 1'b0);
        send_loop(32'd630, 12'd3599, 1'b1);       // rising while latched
        send_loop(32'd640, 12'd2501, 1'b0);
        send_frame(32'd650, 11'd2, 8'd0);         // cancel saves resume speed
        send_loop(32'd1070, 12'd3501, 1'b0);      // silence exactly at timeout
        send_loop(32'd1071, 12'd1501, 1'b0);      // one past timeout
        send_frame(32'hFFFF_FFF0, 11'd1, 8'd1);
        send_loop(32'h0000_0010, 12'd3600, 1'b0); // time wraps
    endtask

    task automatic test_limits_config();
        apply_config(16'd1, 16'd65535, 8'd255, 8'd0, 11'd0, 11'd2047);
        clock_ms = 32'd20;
        random_traffic(100);
    endtask

    task automatic test_equal_ids();
        apply_config(16'd65535, 16'd1, 8'd0, 8'd255, 11'h555, 11'h555);
        clock_ms = 32'hFFFF_FF00;
        random_traffic(60);
    endtask

    task automatic test_steady_random();
        apply_config(16'($urandom_range(20, 300)), 16'($urandom_range(300, 2000)),
                     8'($urandom_range(1, 20)), 8'($urandom), 11'($urandom), 11'($urandom));
        clock_ms = $urandom;
        steady_flow = 1'b1;
        random_traffic(40);
        steady_flow = 1'b0;
        random_traffic(80);
    endtask

    task automatic test_backpressure();
        steady_flow = 1'b1;
        long_stall_req = 1'b1;
        random_traffic(30);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_config();
        int phase;
        for (phase = 0; phase < 2; phase++) begin
            apply_config(16'($urandom_range(1, 400)), 16'($urandom_range(200, 65535)),
                         8'($urandom), 8'($urandom), 11'($urandom), 11'($urandom));
            random_traffic(50);
        end
    endtask

    // ---------------- result side ----------------

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (long_stall_req) begin
                // long hold-off so the block fills and stops taking requests
                long_stall_req = 1'b0;
                hold = 299;
                m_axis_tready <= 1'b0;
            end else if (steady_flow || $urandom_range(0, 99) >= 25) begin
                m_axis_tready <= 1'b1;
            end else begin
                hold = gap_length() - 1;
                m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_reports
        csc_pkg::csc_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (report_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h/%h", $time,
                         m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = report_queue.pop_front();
                compare_field("frames_valid", 64'(want.frames_valid), 64'(m_axis_tuser));
                compare_field("ignition_on", 64'(want.ignition_on), 64'(m_axis_tdata[0]));
                compare_field("cruise_on", 64'(want.cruise_on), 64'(m_axis_tdata[1]));
                compare_field("cruise_frame", want.cruise_frame, m_axis_tdata[65:2]);
                compare_field("speed_frame", want.speed_frame, m_axis_tdata[129:66]);
                compare_field("tdata pad", 64'd0, 64'(m_axis_tdata[135:130]));
            end
        end
    end

    // ---------------- run ----------------

    initial begin : watchdog
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : run
        int guard;
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_button_ladder();
        test_limits_config();
        test_equal_ids();
        test_steady_random();
        test_backpressure();
        test_random_config();
        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 20000 && report_queue.size() != 0; guard++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (report_queue.size() != 0) begin
            $display("%0t: %0d results expected, none arrived", $time, report_queue.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_step.sv
rtl/cruise_stalk_controller_unit.sv
dv/tb_cruise_stalk_controller_unit.sv
